// ===== hw/rtl/i2cms_pkg.sv =====
// i2cms_pkg: shared types and codes for the two-slot I2C master sequencer.
// No dependencies; imported by every module of the block (the interfaces do not import it).
package i2cms_pkg;

    localparam int CW = 6;
    localparam logic [CW-1:0] MAX_OUT = 6'd32;

    localparam logic [2:0] REQ_STAGE   = 3'd0;
    localparam logic [2:0] REQ_WRITE   = 3'd1;
    localparam logic [2:0] REQ_STRING  = 3'd2;
    localparam logic [2:0] REQ_COUNTED = 3'd3;
    localparam logic [2:0] REQ_BUS     = 3'd4;

    localparam logic [1:0] OP_NOP    = 2'd0;
    localparam logic [1:0] OP_STAGE  = 2'd1;
    localparam logic [1:0] OP_SUBMIT = 2'd2;
    localparam logic [1:0] OP_BUS    = 2'd3;

    localparam logic [1:0] KIND_WRITE   = 2'd0;
    localparam logic [1:0] KIND_STRING  = 2'd1;
    localparam logic [1:0] KIND_COUNTED = 2'd2;

    localparam logic [2:0] CMD_NONE  = 3'd0;
    localparam logic [2:0] CMD_START = 3'd1;
    localparam logic [2:0] CMD_TX    = 3'd2;
    localparam logic [2:0] CMD_RX    = 3'd3;
    localparam logic [2:0] CMD_ACK   = 3'd4;
    localparam logic [2:0] CMD_STOP  = 3'd5;

    localparam logic [1:0] DK_NONE  = 2'd0;
    localparam logic [1:0] DK_WRITE = 2'd1;
    localparam logic [1:0] DK_READ  = 2'd2;

    typedef struct packed {
        logic [1:0]    op;
        logic [1:0]    kind;
        logic [6:0]    addr;
        logic [7:0]    dbyte;
        logic [CW-1:0] count;
        logic [7:0]    rx;
    } item_t;

endpackage

// ===== hw/rtl/i2cms_in_if.sv =====
// i2cms_in_if: request channel of the sequencer (valid/ready plus input fields).
// Depends on nothing.
interface i2cms_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] req_type;
    logic [6:0] target_address;
    logic [7:0] data_byte;
    logic [5:0] byte_count;
    logic [7:0] rx_byte;

    modport source (output valid, output req_type, output target_address,
                    output data_byte, output byte_count, output rx_byte, input ready);
    modport sink   (input valid, input req_type, input target_address,
                    input data_byte, input byte_count, input rx_byte, output ready);
endinterface

// ===== hw/rtl/i2cms_out_if.sv =====
// i2cms_out_if: result channel of the sequencer (valid/ready plus result fields).
// Depends on nothing.
interface i2cms_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] bus_cmd;
    logic [7:0] tx_byte;
    logic [1:0] done_kind;
    logic [7:0] read_data;
    logic       last;
    logic       dropped;

    modport source (output valid, output bus_cmd, output tx_byte, output done_kind,
                    output read_data, output last, output dropped, input ready);
    modport sink   (input valid, input bus_cmd, input tx_byte, input done_kind,
                    input read_data, input last, input dropped, output ready);
endinterface

// ===== hw/rtl/i2cms_front.sv =====
// i2cms_front: accepts requests, decodes the request type and clamps counts.
// Depends on i2cms_pkg and i2cms_in_if; feeds i2cms_queue.
module i2cms_front #(
    parameter int SLOT_BYTES = 32
) (
    i2cms_in_if.sink         req,
    input  logic             full,
    output logic             push,
    output i2cms_pkg::item_t item
);
    import i2cms_pkg::*;

    localparam logic [CW-1:0] SB_C = CW'(SLOT_BYTES);

    logic [CW-1:0] clamped;

    assign req.ready = !full;
    assign push      = req.valid && !full;
    assign clamped   = (req.byte_count > SB_C) ? SB_C : req.byte_count;

    always_comb
    begin
        item.addr  = req.target_address;
        item.dbyte = req.data_byte;
        item.rx    = req.rx_byte;
        item.count = clamped;
        item.kind  = KIND_WRITE;
        case (req.req_type)
            REQ_STAGE:   item.op = OP_STAGE;
            REQ_WRITE:   item.op = OP_SUBMIT;
            REQ_STRING:
            begin
                item.op    = OP_SUBMIT;
                item.kind  = KIND_STRING;
                item.count = '0;
            end
            REQ_COUNTED:
            begin
                item.op   = OP_SUBMIT;
                item.kind = KIND_COUNTED;
            end
            REQ_BUS:     item.op = OP_BUS;
            default:     item.op = OP_NOP;
        endcase
    end
endmodule

// ===== hw/rtl/i2cms_queue.sv =====
// i2cms_queue: two-entry request queue between front and back.
// Depends on i2cms_pkg.
module i2cms_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  i2cms_pkg::item_t push_item,
    output logic             full,
    input  logic             pop,
    output logic             q_valid,
    output i2cms_pkg::item_t q_item
);
    import i2cms_pkg::*;

    item_t      entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_pop;

    assign full    = cnt_reg == 2'd2;
    assign q_valid = cnt_reg != 2'd0;
    assign q_item  = entry_reg[rd_ptr_reg];
    assign do_pop  = pop && q_valid;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + (push ? 2'd1 : 2'd0) - (do_pop ? 2'd1 : 2'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3) else $error("queue count overflow");
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push) else $error("push into full queue");
    a_pop_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (do_pop && !push) |=> (cnt_reg == $past(cnt_reg) - 2'd1))
        else $error("pop did not drain queue");
endmodule

// ===== hw/rtl/i2cms_back.sv =====
// i2cms_back: slot state, transaction sequencer, slot buffer memory, result register.
// Depends on i2cms_pkg and i2cms_out_if; fed by i2cms_queue.
module i2cms_back #(
    parameter int SLOT_BYTES   = 32,
    parameter int PACKET_BYTES = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    input  i2cms_pkg::item_t q_item,
    output logic             q_pop,
    i2cms_out_if.source      res
);
    import i2cms_pkg::*;

    localparam int DEPTH = 2 * SLOT_BYTES;
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = $clog2(SLOT_BYTES + 1);
    localparam logic [PW-1:0] SB_P = PW'(SLOT_BYTES);
    localparam logic [CW-1:0] PB_C = CW'(PACKET_BYTES);

    localparam logic [2:0] PH_STARTED = 3'd0;
    localparam logic [2:0] PH_SENDING = 3'd1;
    localparam logic [2:0] PH_WAIT_RX = 3'd2;
    localparam logic [2:0] PH_GOT_RX  = 3'd3;
    localparam logic [2:0] PH_STOPPED = 3'd4;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_TX   = 2'd1;
    localparam logic [1:0] ST_RD   = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    function automatic logic [AW-1:0] buf_addr(input logic s, input logic [CW-1:0] i);
        buf_addr = AW'(int'(i) + (s ? SLOT_BYTES : 0));
    endfunction

    logic [7:0]    slot_mem [DEPTH];
    logic [7:0]    rd_data_reg;

    logic [1:0]    slot_busy_reg, slot_busy_next;
    logic [6:0]    slot_addr_reg [2];
    logic [6:0]    slot_addr_next [2];
    logic [1:0]    slot_kind_reg [2];
    logic [1:0]    slot_kind_next [2];
    logic [CW-1:0] slot_count_reg [2];
    logic [CW-1:0] slot_count_next [2];
    logic          serving_reg, serving_next;
    logic          serving_slot_reg, serving_slot_next;
    logic [2:0]    phase_reg, phase_next;
    logic [PW-1:0] progress_reg, progress_next;
    logic [PW-1:0] stage_index_reg, stage_index_next;
    logic [1:0]    state_reg, state_next;

    logic          str_slot_reg, str_slot_next;
    logic [CW-1:0] str_prog_reg, str_prog_next;
    logic [CW-1:0] str_n_reg, str_n_next;
    logic [CW-1:0] str_idx_reg, str_idx_next;
    logic [2:0]    str_cmd_reg, str_cmd_next;

    logic          out_valid_reg, out_valid_next;
    logic [2:0]    out_cmd_reg, out_cmd_next;
    logic [7:0]    out_tx_reg, out_tx_next;
    logic [1:0]    out_dk_reg, out_dk_next;
    logic [7:0]    out_rd_reg, out_rd_next;
    logic          out_last_reg, out_last_next;
    logic          out_drop_reg, out_drop_next;

    logic          mem_we, mem_re;
    logic [AW-1:0] mem_wa, mem_ra;
    logic [7:0]    mem_wd;

    logic          out_free;
    logic          sl, vac_s, other_busy;
    logic [1:0]    busy_after;
    logic [CW-1:0] prog_c, cnt_c, n_full, n_clip;
    logic [PW-1:0] p1;
    logic          stop;

    assign out_free = !out_valid_reg || res.ready;
    assign sl       = serving_slot_reg;
    assign vac_s    = slot_busy_reg[0];
    assign prog_c   = CW'(progress_reg);
    assign cnt_c    = slot_count_reg[sl];

    always_comb
    begin
        slot_busy_next    = slot_busy_reg;
        slot_addr_next    = slot_addr_reg;
        slot_kind_next    = slot_kind_reg;
        slot_count_next   = slot_count_reg;
        serving_next      = serving_reg;
        serving_slot_next = serving_slot_reg;
        phase_next        = phase_reg;
        progress_next     = progress_reg;
        stage_index_next  = stage_index_reg;
        state_next        = state_reg;
        str_slot_next     = str_slot_reg;
        str_prog_next     = str_prog_reg;
        str_n_next        = str_n_reg;
        str_idx_next      = str_idx_reg;
        str_cmd_next      = str_cmd_reg;
        out_valid_next    = out_valid_reg && !res.ready;
        out_cmd_next      = out_cmd_reg;
        out_tx_next       = out_tx_reg;
        out_dk_next       = out_dk_reg;
        out_rd_next       = out_rd_reg;
        out_last_next     = out_last_reg;
        out_drop_next     = out_drop_reg;
        mem_we            = 1'b0;
        mem_wa            = '0;
        mem_wd            = q_item.dbyte;
        mem_re            = 1'b0;
        mem_ra            = '0;
        q_pop             = 1'b0;
        busy_after        = slot_busy_reg;
        other_busy        = 1'b0;
        n_full            = '0;
        n_clip            = '0;
        p1                = progress_reg;
        stop              = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid && out_free)
                begin
                    q_pop          = 1'b1;
                    out_valid_next = 1'b1;
                    out_cmd_next   = CMD_NONE;
                    out_tx_next    = '0;
                    out_dk_next    = DK_NONE;
                    out_rd_next    = '0;
                    out_last_next  = 1'b1;
                    out_drop_next  = 1'b0;
                    case (q_item.op)
                        OP_STAGE:
                        begin
                            if (&slot_busy_reg)
                            begin
                                out_drop_next = 1'b1;
                            end
                            else if (stage_index_reg < SB_P)
                            begin
                                mem_we           = 1'b1;
                                mem_wa           = buf_addr(vac_s, CW'(stage_index_reg));
                                stage_index_next = stage_index_reg + 1'b1;
                            end
                        end
                        OP_SUBMIT:
                        begin
                            stage_index_next = '0;
                            if (&slot_busy_reg)
                            begin
                                out_drop_next = 1'b1;
                            end
                            else
                            begin
                                busy_after            = slot_busy_reg;
                                busy_after[vac_s]     = 1'b1;
                                slot_busy_next        = busy_after;
                                slot_addr_next[vac_s]  = q_item.addr;
                                slot_kind_next[vac_s]  = q_item.kind;
                                slot_count_next[vac_s] = q_item.count;
                                if (!serving_reg)
                                begin
                                    serving_next      = 1'b1;
                                    serving_slot_next = !busy_after[0];
                                    phase_next        = PH_STARTED;
                                    progress_next     = '0;
                                    out_cmd_next      = CMD_START;
                                end
                            end
                        end
                        OP_BUS:
                        begin
                            if (serving_reg)
                            begin
                                case (phase_reg)
                                    PH_STARTED:
                                    begin
                                        phase_next   = (slot_kind_reg[sl] == KIND_WRITE) ?
                                                       PH_SENDING : PH_WAIT_RX;
                                        out_cmd_next = CMD_TX;
                                        out_tx_next  = {slot_addr_reg[sl],
                                                        slot_kind_reg[sl] != KIND_WRITE};
                                    end
                                    PH_SENDING:
                                    begin
                                        if (prog_c < cnt_c && progress_reg < SB_P)
                                        begin
                                            mem_re         = 1'b1;
                                            mem_ra         = buf_addr(sl, prog_c);
                                            progress_next  = progress_reg + 1'b1;
                                            out_valid_next = out_valid_reg && !res.ready;
                                            state_next     = ST_TX;
                                        end
                                        else
                                        begin
                                            phase_next   = PH_STOPPED;
                                            out_cmd_next = CMD_STOP;
                                        end
                                    end
                                    PH_WAIT_RX:
                                    begin
                                        phase_next   = PH_GOT_RX;
                                        out_cmd_next = CMD_RX;
                                    end
                                    PH_GOT_RX:
                                    begin
                                        if (progress_reg < SB_P)
                                        begin
                                            mem_we = 1'b1;
                                            mem_wa = buf_addr(sl, prog_c);
                                            mem_wd = q_item.rx;
                                            p1     = progress_reg + 1'b1;
                                        end
                                        progress_next = p1;
                                        if (slot_kind_reg[sl] == KIND_STRING)
                                        begin
                                            stop = q_item.rx == 8'd0;
                                        end
                                        else
                                        begin
                                            stop = CW'(p1) >= cnt_c;
                                        end
                                        if (p1 >= SB_P)
                                        begin
                                            stop = 1'b1;
                                        end
                                        phase_next   = stop ? PH_STOPPED : PH_WAIT_RX;
                                        out_cmd_next = stop ? CMD_STOP : CMD_ACK;
                                    end
                                    PH_STOPPED:
                                    begin
                                        if (slot_kind_reg[sl] == KIND_WRITE)
                                        begin
                                            n_clip = '0;
                                        end
                                        else
                                        begin
                                            n_full = (slot_kind_reg[sl] == KIND_STRING) ?
                                                     PB_C : prog_c;
                                            n_clip = (n_full > MAX_OUT) ? MAX_OUT : n_full;
                                        end
                                        slot_busy_next[sl] = 1'b0;
                                        serving_next       = 1'b0;
                                        other_busy         = slot_busy_reg[!sl];
                                        if (!sl && !slot_busy_reg[1])
                                        begin
                                            stage_index_next = '0;
                                        end
                                        if (other_busy)
                                        begin
                                            serving_next      = 1'b1;
                                            serving_slot_next = !sl;
                                            phase_next        = PH_STARTED;
                                            progress_next     = '0;
                                        end
                                        if (n_clip == '0)
                                        begin
                                            out_cmd_next = other_busy ? CMD_START : CMD_NONE;
                                            out_dk_next  = DK_WRITE;
                                        end
                                        else
                                        begin
                                            out_valid_next = out_valid_reg && !res.ready;
                                            str_slot_next  = sl;
                                            str_prog_next  = prog_c;
                                            str_n_next     = n_clip;
                                            str_idx_next   = '0;
                                            str_cmd_next   = other_busy ? CMD_START : CMD_NONE;
                                            state_next     = ST_RD;
                                        end
                                    end
                                    default:
                                    begin
                                        out_cmd_next = CMD_NONE;
                                    end
                                endcase
                            end
                        end
                        default:
                        begin
                            out_cmd_next = CMD_NONE;
                        end
                    endcase
                end
            end
            ST_TX:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_cmd_next   = CMD_TX;
                    out_tx_next    = rd_data_reg;
                    out_dk_next    = DK_NONE;
                    out_rd_next    = '0;
                    out_last_next  = 1'b1;
                    out_drop_next  = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            ST_RD:
            begin
                if (str_idx_reg < str_prog_reg)
                begin
                    mem_re = 1'b1;
                    mem_ra = buf_addr(str_slot_reg, str_idx_reg);
                end
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_tx_next    = '0;
                    out_dk_next    = DK_READ;
                    out_rd_next    = (str_idx_reg < str_prog_reg) ? rd_data_reg : 8'd0;
                    out_drop_next  = 1'b0;
                    out_last_next  = str_idx_reg == str_n_reg - 1'b1;
                    out_cmd_next   = out_last_next ? str_cmd_reg : CMD_NONE;
                    str_idx_next   = str_idx_reg + 1'b1;
                    state_next     = out_last_next ? ST_IDLE : ST_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_busy_reg     <= '0;
            slot_addr_reg     <= '{default: '0};
            slot_kind_reg     <= '{default: '0};
            slot_count_reg    <= '{default: '0};
            serving_reg       <= 1'b0;
            serving_slot_reg  <= 1'b0;
            phase_reg         <= PH_STARTED;
            progress_reg      <= '0;
            stage_index_reg   <= '0;
            state_reg         <= ST_IDLE;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            slot_busy_reg     <= slot_busy_next;
            slot_addr_reg     <= slot_addr_next;
            slot_kind_reg     <= slot_kind_next;
            slot_count_reg    <= slot_count_next;
            serving_reg       <= serving_next;
            serving_slot_reg  <= serving_slot_next;
            phase_reg         <= phase_next;
            progress_reg      <= progress_next;
            stage_index_reg   <= stage_index_next;
            state_reg         <= state_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        str_slot_reg <= str_slot_next;
        str_prog_reg <= str_prog_next;
        str_n_reg    <= str_n_next;
        str_idx_reg  <= str_idx_next;
        str_cmd_reg  <= str_cmd_next;
        out_cmd_reg  <= out_cmd_next;
        out_tx_reg   <= out_tx_next;
        out_dk_reg   <= out_dk_next;
        out_rd_reg   <= out_rd_next;
        out_last_reg <= out_last_next;
        out_drop_reg <= out_drop_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[mem_wa] <= mem_wd;
        end
        if (mem_re)
        begin
            rd_data_reg <= slot_mem[mem_ra];
        end
    end

    assign res.valid     = out_valid_reg;
    assign res.bus_cmd   = out_cmd_reg;
    assign res.tx_byte   = out_tx_reg;
    assign res.done_kind = out_dk_reg;
    assign res.read_data = out_rd_reg;
    assign res.last      = out_last_reg;
    assign res.dropped   = out_drop_reg;

    a_serving_busy: assert property (@(posedge clk) disable iff (!rst_n)
        serving_reg |-> slot_busy_reg[serving_slot_reg])
        else $error("serving a vacant slot");
    a_stage_bound: assert property (@(posedge clk) disable iff (!rst_n)
        stage_index_reg <= SB_P) else $error("stage index past slot size");
    a_progress_bound: assert property (@(posedge clk) disable iff (!rst_n)
        progress_reg <= SB_P) else $error("progress past slot size");
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (state_reg == ST_IDLE)) else $error("pop while busy");
    a_stream_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (str_n_reg != '0 && str_idx_reg < str_n_reg))
        else $error("stream index out of range");
endmodule

// ===== hw/rtl/i2c_master_two_slot_sequencer_unit.sv =====
// i2c_master_two_slot_sequencer_unit: top level of the two-slot I2C master sequencer.
// Depends on i2cms_pkg, i2cms_in_if, i2cms_out_if, i2cms_front, i2cms_queue, i2cms_back.
//
// Usage: requests arrive on req (valid/ready): stage byte, submit write, submit
// string read, submit counted read, or bus-done event. Results leave on res
// (valid/ready); every request yields one or more results, the final one with
// last set. A counted read completion streams one result per returned byte, a string
// read PACKET_BYTES zero-padded ones (both capped at MAX_OUT). The front decodes each
// request into a two-entry queue; the back executes one queued request at a time and
// keeps slot state and a 2*SLOT_BYTES byte memory. A plain request passes through the
// queue and the back's result register; a write byte transmit adds a registered buffer
// read (ST_TX); a read completion sends each byte through a registered memory read
// (ST_RD) and then the result register (ST_EMIT). The back pops no new request while
// it sends a byte or streams a completion; its single result register holds on stall.
// Reset clears slots, sequencer state and queue; buffer contents stay undefined.
// When res stalls, the result register holds, the back waits and the queue
// fills; req.ready drops once both queue entries are taken.
module i2c_master_two_slot_sequencer_unit #(
    parameter int SLOT_BYTES   = 32,
    parameter int PACKET_BYTES = 32
) (
    input logic         clk,
    input logic         rst_n,
    i2cms_in_if.sink    req,
    i2cms_out_if.source res
);
    import i2cms_pkg::*;

    item_t push_item;
    item_t q_item;
    logic  push, full, pop, q_valid;

    i2cms_front #(
        .SLOT_BYTES (SLOT_BYTES)
    ) u_front (
        .req  (req),
        .full (full),
        .push (push),
        .item (push_item)
    );

    i2cms_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (full),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_item    (q_item)
    );

    i2cms_back #(
        .SLOT_BYTES   (SLOT_BYTES),
        .PACKET_BYTES (PACKET_BYTES)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (pop),
        .res     (res)
    );
endmodule

// ===== verif/i2c_master_two_slot_sequencer_unit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the two-slot I2C master sequencer: directed and random
// requests, cycle-free prediction, in-order result checking. Needs i2cms_pkg,
// i2cms_in_if, i2cms_out_if and the RTL of i2c_master_two_slot_sequencer_unit.
module i2c_master_two_slot_sequencer_unit_tb;
    import i2cms_pkg::*;

    localparam int SLOT_BYTES   = 32;
    localparam int PACKET_BYTES = 32;
    localparam int QUIET_LIMIT  = 2000;
    localparam int TAIL_CYCLES  = 80;

    typedef enum logic [2:0] {
        BP_ADDRESS,
        BP_WRITE,
        BP_RX_ARM,
        BP_RX_TAKE,
        BP_FINISH
    } bus_phase_e;

    typedef struct packed {
        logic [2:0] bus_cmd;
        logic [7:0] tx_byte;
        logic [1:0] done_kind;
        logic [7:0] read_data;
        logic       last;
        logic       dropped;
    } bus_result_t;

    logic clk;
    logic rst_n;

    i2cms_in_if  req_ch ();
    i2cms_out_if res_ch ();

    i2c_master_two_slot_sequencer_unit #(
        .SLOT_BYTES   (SLOT_BYTES),
        .PACKET_BYTES (PACKET_BYTES)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .res   (res_ch)
    );

    // sequencer mirror
    logic       slot_busy   [2];
    logic [6:0] slot_addr   [2];
    logic [1:0] slot_kind   [2];
    logic [5:0] slot_len    [2];
    logic [7:0] slot_mem    [2*SLOT_BYTES];
    logic       slot_mem_ok [2*SLOT_BYTES];
    logic       active;
    logic       active_slot;
    bus_phase_e bus_phase;
    logic [5:0] done_bytes;
    logic [5:0] stage_ptr;

    bus_result_t bus_result_q[$];

    int  mismatch_count = 0;
    int  work_items     = 0;
    int  src_idle_pct   = 0;
    int  sink_idle_pct  = 0;
    int  sink_hold      = 0;
    int  quiet_cycles   = 0;
    int  stage_plan     = 0;
    int  write_len      = 0;
    bit  write_pending  = 0;
    bit  long_string [2];

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic void mirror_reset();
        int k;
        for (k = 0; k < 2; k++) begin
            slot_busy[k]   = 1'b0;
            slot_addr[k]   = '0;
            slot_kind[k]   = KIND_WRITE;
            slot_len[k]    = '0;
            long_string[k] = 1'b0;
        end
        for (k = 0; k < 2*SLOT_BYTES; k++)
            slot_mem_ok[k] = 1'b0;
        active      = 1'b0;
        active_slot = 1'b0;
        bus_phase   = BP_ADDRESS;
        done_bytes  = '0;
        stage_ptr   = '0;
    endfunction

    function automatic int first_free();
        if (!slot_busy[0])
            return 0;
        if (!slot_busy[1])
            return 1;
        return -1;
    endfunction

    function automatic logic [2:0] launch_next();
        if (active)
            return CMD_NONE;
        if (slot_busy[0])
            active_slot = 1'b0;
        else if (slot_busy[1])
            active_slot = 1'b1;
        else
            return CMD_NONE;
        active     = 1'b1;
        bus_phase  = BP_ADDRESS;
        done_bytes = '0;
        return CMD_START;
    endfunction

    function automatic int staged_run(input int s);
        int k;
        k = 0;
        while (k < SLOT_BYTES && slot_mem_ok[s*SLOT_BYTES + k])
            k++;
        return k;
    endfunction

    function automatic bus_result_t mk_result(input logic [2:0] cmd, input logic [7:0] tx,
                                              input logic [1:0] dk, input logic [7:0] rd,
                                              input logic drop);
        return {cmd, tx, dk, rd, 1'b0, drop};
    endfunction

    task automatic predict_request(input logic [2:0] rt, input logic [6:0] ta,
                                   input logic [7:0] db, input logic [5:0] bc,
                                   input logic [7:0] rb);
        bus_result_t batch[$];
        int          s;
        int          base;
        int          n;
        int          i;
        logic        sl;
        logic [1:0]  kind;
        logic [2:0]  nxt;
        logic        halt;
        batch = {};
        if (!(rt > REQ_BUS || (rt == REQ_BUS && !active)))
            work_items++;
        if (rt == REQ_STAGE) begin
            s = first_free();
            if (s < 0)
                batch.push_back(mk_result(CMD_NONE, 8'h00, DK_NONE, 8'h00, 1'b1));
            else begin
                if (stage_ptr < SLOT_BYTES) begin
                    slot_mem[s*SLOT_BYTES + int'(stage_ptr)]    = db;
                    slot_mem_ok[s*SLOT_BYTES + int'(stage_ptr)] = 1'b1;
                    stage_ptr++;
                end
                batch.push_back(mk_result(CMD_NONE, 8'h00, DK_NONE, 8'h00, 1'b0));
            end
        end else if (rt == REQ_WRITE || rt == REQ_STRING || rt == REQ_COUNTED) begin
            stage_ptr = '0;
            s = first_free();
            if (s < 0)
                batch.push_back(mk_result(CMD_NONE, 8'h00, DK_NONE, 8'h00, 1'b1));
            else begin
                slot_busy[s] = 1'b1;
                slot_addr[s] = ta;
                slot_kind[s] = (rt == REQ_WRITE) ? KIND_WRITE :
                               (rt == REQ_STRING) ? KIND_STRING : KIND_COUNTED;
                if (rt == REQ_STRING)
                    slot_len[s] = '0;
                else
                    slot_len[s] = (bc > SLOT_BYTES) ? 6'(SLOT_BYTES) : bc;
                batch.push_back(mk_result(launch_next(), 8'h00, DK_NONE, 8'h00, 1'b0));
            end
        end else if (rt == REQ_BUS && active) begin
            sl   = active_slot;
            kind = slot_kind[sl];
            base = sl ? SLOT_BYTES : 0;
            case (bus_phase)
                BP_ADDRESS: begin
                    bus_phase = (kind == KIND_WRITE) ? BP_WRITE : BP_RX_ARM;
                    batch.push_back(mk_result(CMD_TX, {slot_addr[sl], kind != KIND_WRITE},
                                              DK_NONE, 8'h00, 1'b0));
                end
                BP_WRITE: begin
                    if (done_bytes < slot_len[sl] && done_bytes < SLOT_BYTES) begin
                        batch.push_back(mk_result(CMD_TX, slot_mem[base + int'(done_bytes)],
                                                  DK_NONE, 8'h00, 1'b0));
                        done_bytes++;
                    end else begin
                        bus_phase = BP_FINISH;
                        batch.push_back(mk_result(CMD_STOP, 8'h00, DK_NONE, 8'h00, 1'b0));
                    end
                end
                BP_RX_ARM: begin
                    bus_phase = BP_RX_TAKE;
                    batch.push_back(mk_result(CMD_RX, 8'h00, DK_NONE, 8'h00, 1'b0));
                end
                BP_RX_TAKE: begin
                    if (done_bytes < SLOT_BYTES) begin
                        slot_mem[base + int'(done_bytes)]    = rb;
                        slot_mem_ok[base + int'(done_bytes)] = 1'b1;
                        done_bytes++;
                    end
                    if (kind == KIND_STRING)
                        halt = (rb == 8'h00);
                    else
                        halt = (done_bytes >= slot_len[sl]);
                    if (done_bytes >= SLOT_BYTES)
                        halt = 1'b1;
                    bus_phase = halt ? BP_FINISH : BP_RX_ARM;
                    batch.push_back(mk_result(halt ? CMD_STOP : CMD_ACK, 8'h00, DK_NONE,
                                              8'h00, 1'b0));
                end
                BP_FINISH: begin
                    n = 0;
                    if (kind != KIND_WRITE) begin
                        n = (kind == KIND_STRING) ? PACKET_BYTES : int'(done_bytes);
                        if (n > int'(MAX_OUT))
                            n = int'(MAX_OUT);
                        for (i = 0; i < n; i++)
                            batch.push_back(mk_result(CMD_NONE, 8'h00, DK_READ,
                                (i < done_bytes && i < SLOT_BYTES) ? slot_mem[base + i] : 8'h00,
                                1'b0));
                    end
                    slot_busy[sl] = 1'b0;
                    active        = 1'b0;
                    // A freed while B vacant: bytes staged for B are lost
                    if (!sl && !slot_busy[1])
                        stage_ptr = '0;
                    nxt = launch_next();
                    if (n == 0)
                        batch.push_back(mk_result(nxt, 8'h00, DK_WRITE, 8'h00, 1'b0));
                    else
                        batch[batch.size()-1].bus_cmd = nxt;
                end
                default:
                    batch.push_back(mk_result(CMD_NONE, 8'h00, DK_NONE, 8'h00, 1'b0));
            endcase
        end else
            batch.push_back(mk_result(CMD_NONE, 8'h00, DK_NONE, 8'h00, 1'b0));
        batch[batch.size()-1].last = 1'b1;
        foreach (batch[i])
            bus_result_q.push_back(batch[i]);
    endtask

    task automatic send_request(input logic [2:0] rt, input logic [6:0] ta,
                                input logic [7:0] db, input logic [5:0] bc,
                                input logic [7:0] rb);
        while ($urandom_range(99) < src_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid          <= 1'b1;
        req_ch.req_type       <= rt;
        req_ch.target_address <= ta;
        req_ch.data_byte      <= db;
        req_ch.byte_count     <= bc;
        req_ch.rx_byte        <= rb;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        predict_request(rt, ta, db, bc, rb);
    endtask

    task automatic bus_done(input logic [7:0] rb);
        send_request(REQ_BUS, 7'($urandom), 8'($urandom), 6'($urandom_range(32)), rb);
    endtask

    task automatic stage_byte(input logic [7:0] db);
        send_request(REQ_STAGE, 7'($urandom), db, 6'($urandom_range(32)), 8'($urandom));
    endtask

    task automatic submit_read(input logic [2:0] rt, input logic [6:0] ta, input logic [5:0] bc);
        send_request(rt, ta, 8'($urandom), bc, 8'($urandom));
    endtask

    // never ask for more bytes than the target slot holds
    task automatic submit_write(input logic [6:0] ta, input int want);
        int s;
        int cap;
        s   = first_free();
        cap = (s < 0) ? SLOT_BYTES : staged_run(s);
        if (want > cap)
            want = cap;
        send_request(REQ_WRITE, ta, 8'($urandom), 6'(want), 8'($urandom));
    endtask

    function automatic int pick_len();
        int r;
        r = $urandom_range(99);
        if (r < 80)
            return $urandom_range(5);
        if (r < 92)
            return $urandom_range(16, 6);
        return $urandom_range(32, 29);
    endfunction

    function automatic logic [7:0] pick_rx();
        if (active && slot_kind[active_slot] == KIND_STRING && bus_phase == BP_RX_TAKE) begin
            if (!long_string[active_slot] && $urandom_range(3) == 0)
                return 8'h00;
            return 8'($urandom_range(255, 1));
        end
        return 8'($urandom);
    endfunction

    task automatic noise_request();
        logic [2:0] rt;
        rt = 3'($urandom_range(7));
        if (rt == REQ_WRITE)
            submit_write(7'($urandom), $urandom_range(32));
        else
            send_request(rt, 7'($urandom), 8'($urandom), 6'($urandom_range(32)), 8'($urandom));
    endtask

    task automatic random_step();
        int r;
        int s;
        r = $urandom_range(99);
        s = first_free();
        if (r < 8)
            noise_request();
        else if (active && (r < 55 || s < 0))
            bus_done(pick_rx());
        else if (stage_plan > 0) begin
            stage_byte(8'($urandom));
            stage_plan--;
        end else if (write_pending) begin
            write_pending = 1'b0;
            submit_write(7'($urandom),
                         ($urandom_range(3) == 0) ? $urandom_range(write_len) : write_len);
        end else begin
            case ($urandom_range(2))
                0: begin
                    stage_plan    = pick_len();
                    write_len     = stage_plan;
                    // overrun the slot so extra bytes get ignored
                    if (stage_plan >= 30)
                        stage_plan += 3;
                    write_pending = 1'b1;
                end
                1: begin
                    if (s >= 0)
                        long_string[s] = ($urandom_range(99) < 15);
                    submit_read(REQ_STRING, 7'($urandom), 6'($urandom_range(32)));
                end
                default:
                    submit_read(REQ_COUNTED, 7'($urandom), 6'(pick_len()));
            endcase
        end
    endtask

    task automatic test_ignored_requests();
        bus_done(8'hFF);
        send_request(3'd5, 7'h7F, 8'hFF, 6'd32, 8'hFF);
        send_request(3'd7, 7'h00, 8'h00, 6'd0, 8'h00);
    endtask

    task automatic test_write_transfer();
        stage_byte(8'h00);
        stage_byte(8'hFF);
        submit_write(7'h7F, 2);
        repeat (5)
            bus_done(8'($urandom));
    endtask

    task automatic test_counted_read_of_zero();
        submit_read(REQ_COUNTED, 7'h00, 6'd0);
        bus_done(8'h00);
        bus_done(8'h00);
        bus_done(8'hFF);
        bus_done(8'h00);
    endtask

    task automatic test_string_read();
        submit_read(REQ_STRING, 7'h2A, 6'd5);
        bus_done(8'h00);
        bus_done(8'h00);
        bus_done(8'h81);
        bus_done(8'h00);
        bus_done(8'h00);
        bus_done(8'h00);
    endtask

    // leaves a full-length counted read in slot B for the random part to finish
    task automatic test_both_slots_full();
        submit_write(7'h01, 0);
        submit_read(REQ_COUNTED, 7'h40, 6'd32);
        submit_read(REQ_STRING, 7'h33, 6'd0);
        stage_byte(8'hC3);
    endtask

    task automatic test_random_traffic(input int src_pct, input int sink_pct, input int n);
        int goal;
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        goal          = work_items + n;
        while (work_items < goal)
            random_step();
    endtask

    task automatic test_result_backpressure();
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        sink_hold     = 150;
        repeat (24)
            random_step();
    endtask

    task automatic log_mismatch(input string why, input bus_result_t want, input bus_result_t seen);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $write("%0t %s: expected cmd=%0d tx=%02h done=%0d rd=%02h last=%0b drop=%0b, ",
                   $time, why, want.bus_cmd, want.tx_byte, want.done_kind, want.read_data,
                   want.last, want.dropped);
            $display("got cmd=%0d tx=%02h done=%0d rd=%02h last=%0b drop=%0b",
                     seen.bus_cmd, seen.tx_byte, seen.done_kind, seen.read_data,
                     seen.last, seen.dropped);
        end
    endtask

    always @(posedge clk) begin
        bus_result_t seen;
        bus_result_t want;
        if (rst_n && res_ch.valid && res_ch.ready) begin
            seen = {res_ch.bus_cmd, res_ch.tx_byte, res_ch.done_kind, res_ch.read_data,
                    res_ch.last, res_ch.dropped};
            if (bus_result_q.size() == 0)
                log_mismatch("result with no request outstanding", '0, seen);
            else begin
                want = bus_result_q.pop_front();
                if (seen !== want)
                    log_mismatch("result mismatch", want, seen);
            end
        end
    end

    initial begin
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (sink_hold > 0) begin
                sink_hold--;
                res_ch.ready <= 1'b0;
            end else
                res_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    always @(posedge clk) begin
        if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        rst_n                 <= 1'b0;
        req_ch.valid          <= 1'b0;
        req_ch.req_type       <= REQ_STAGE;
        req_ch.target_address <= '0;
        req_ch.data_byte      <= '0;
        req_ch.byte_count     <= '0;
        req_ch.rx_byte        <= '0;
        mirror_reset();
        src_idle_pct  = 18;
        sink_idle_pct = 48;
        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;

        test_ignored_requests();
        test_write_transfer();
        test_counted_read_of_zero();
        test_string_read();
        test_both_slots_full();
        test_random_traffic(18, 48, 40);
        test_random_traffic(48, 18, 40);
        test_random_traffic(0, 0, 40);
        test_result_backpressure();

        req_ch.valid <= 1'b0;
        while (bus_result_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES)
            @(posedge clk);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
